### src/cwfa_pkg.sv
// Shared widths, codes and record types of the window fetch address core.
package cwfa_pkg;

   // field widths of the item and result streams
   localparam int IDX_W = 24;
   localparam int POS_W = 20;
   localparam int ROW_W = 20;
   localparam int OFF_W = 24;
   localparam int OCH_W = 16;
   localparam int XY_W  = 12;

   // configuration field widths
   localparam int CHN_W      = 11;
   localparam int MAP_W      = 13;
   localparam int KER_W      = 5;
   localparam int KS_W       = 9;
   localparam int PLANE_W    = 25;
   localparam int W_W        = KS_W - 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // saturation limits of the configuration fields
   localparam logic [CHN_W-1:0] MAX_CHANNELS  = 11'd1024;
   localparam logic [KER_W-1:0] MAX_KERNEL    = 5'd16;
   localparam logic [MAP_W-1:0] MAX_MAP_WIDTH = 13'd4096;

   // pipelined divider shape
   localparam int DIV_NUM_W  = 24;
   localparam int DIV_DEN_W  = 25;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

   // stage map of the whole pipeline
   localparam int STG_IN      = 0;
   localparam int STG_DIV1    = STG_IN + 1;
   localparam int STG_DIV2    = STG_DIV1 + DIV_STAGES;
   localparam int STG_ADDR    = STG_DIV2 + DIV_STAGES;
   localparam int ADDR_STAGES = 3;
   localparam int NUM_STAGES  = STG_ADDR + ADDR_STAGES;

   // stream bus widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAYER_MODE       = 3'd0,
      CSR_INPUT_CHANNELS   = 3'd1,
      CSR_PADDED_ROW_WIDTH = 3'd2,
      CSR_KERNEL_WIDTH     = 3'd3,
      CSR_KERNEL_HEIGHT    = 3'd4,
      CSR_WINDOW_STRIDE    = 3'd5,
      CSR_OUTPUT_WIDTH     = 3'd6,
      CSR_OUTPUT_HEIGHT    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_INPUT  = 2'd0,
      REGION_WEIGHT = 2'd1,
      REGION_BIAS   = 2'd2,
      REGION_NONE   = 2'd3
   } region_type;

   // effective (saturated) configuration plus derived products
   typedef struct packed {
      logic               pool;
      logic [CHN_W-1:0]   chn;
      logic [MAP_W-1:0]   prw;
      logic [KER_W-1:0]   kw;
      logic [KER_W-1:0]   st;
      logic [MAP_W-1:0]   ow;
      logic [KS_W-1:0]    ks;
      logic [PLANE_W-1:0] plane;
   } cfg_type;

   // classification that rides beside the second divider pair
   typedef struct packed {
      region_type       region;
      logic [ROW_W-1:0] ch;
      logic [ROW_W-1:0] k;
      logic [W_W-1:0]   w;
   } side_type;

   typedef struct packed {
      region_type       region;
      logic [ROW_W-1:0] table_row;
      logic [OFF_W-1:0] element_offset;
      logic [OCH_W-1:0] out_channel;
      logic [XY_W-1:0]  out_x;
      logic [XY_W-1:0]  out_y;
   } result_type;

endpackage

### src/cwfa_cfg.sv
// Configuration registers with saturation and derived window and plane sizes.
module cwfa_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cwfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cwfa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output cwfa_pkg::cfg_type              cfg
);
   import cwfa_pkg::*;

   logic               mode_ff,  mode_in;
   logic [CHN_W-1:0]   chn_ff,   chn_in;
   logic [MAP_W-1:0]   prw_ff,   prw_in;
   logic [KER_W-1:0]   kw_ff,    kw_in;
   logic [KER_W-1:0]   kh_ff,    kh_in;
   logic [KER_W-1:0]   st_ff,    st_in;
   logic [MAP_W-1:0]   ow_ff,    ow_in;
   logic [MAP_W-1:0]   oh_ff,    oh_in;
   logic [KS_W-1:0]    ks_ff,    ks_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;

   function automatic logic [KER_W-1:0] cap_kernel(input logic [KER_W-1:0] v);
      return (v > MAX_KERNEL) ? MAX_KERNEL : v;
   endfunction

   function automatic logic [MAP_W-1:0] cap_map(input logic [MAP_W-1:0] v);
      return (v > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : v;
   endfunction

   // output sizes also treat zero as one
   function automatic logic [MAP_W-1:0] cap_size(input logic [MAP_W-1:0] v);
      logic [MAP_W-1:0] c;
      c = cap_map(v);
      return (c == '0) ? MAP_W'(1) : c;
   endfunction

   // store saturated values on write
   always_comb begin
      mode_in = mode_ff;
      chn_in  = chn_ff;
      prw_in  = prw_ff;
      kw_in   = kw_ff;
      kh_in   = kh_ff;
      st_in   = st_ff;
      ow_in   = ow_ff;
      oh_in   = oh_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LAYER_MODE:       mode_in = csr_wdata[0];
            CSR_INPUT_CHANNELS: begin
               chn_in = (csr_wdata[CHN_W-1:0] > MAX_CHANNELS) ? MAX_CHANNELS
                                                              : csr_wdata[CHN_W-1:0];
            end
            CSR_PADDED_ROW_WIDTH: prw_in = cap_map(csr_wdata[MAP_W-1:0]);
            CSR_KERNEL_WIDTH:     kw_in  = cap_kernel(csr_wdata[KER_W-1:0]);
            CSR_KERNEL_HEIGHT:    kh_in  = cap_kernel(csr_wdata[KER_W-1:0]);
            CSR_WINDOW_STRIDE:    st_in  = cap_kernel(csr_wdata[KER_W-1:0]);
            CSR_OUTPUT_WIDTH:     ow_in  = cap_size(csr_wdata[MAP_W-1:0]);
            CSR_OUTPUT_HEIGHT:    oh_in  = cap_size(csr_wdata[MAP_W-1:0]);
            default: ;
         endcase
      end
   end

   // derive window size and output plane size, registered in the cycle after the sizes change
   assign ks_in    = kw_ff * kh_ff;
   assign plane_in = ow_ff * oh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         chn_ff   <= CHN_W'(1);
         prw_ff   <= MAP_W'(1);
         kw_ff    <= KER_W'(1);
         kh_ff    <= KER_W'(1);
         st_ff    <= KER_W'(1);
         ow_ff    <= MAP_W'(1);
         oh_ff    <= MAP_W'(1);
         ks_ff    <= KS_W'(1);
         plane_ff <= PLANE_W'(1);
      end else begin
         mode_ff  <= mode_in;
         chn_ff   <= chn_in;
         prw_ff   <= prw_in;
         kw_ff    <= kw_in;
         kh_ff    <= kh_in;
         st_ff    <= st_in;
         ow_ff    <= ow_in;
         oh_ff    <= oh_in;
         ks_ff    <= ks_in;
         plane_ff <= plane_in;
      end
   end

   assign cfg.pool  = mode_ff;
   assign cfg.chn   = chn_ff;
   assign cfg.prw   = prw_ff;
   assign cfg.kw    = kw_ff;
   assign cfg.st    = st_ff;
   assign cfg.ow    = ow_ff;
   assign cfg.ks    = ks_ff;
   assign cfg.plane = plane_ff;

endmodule

### src/cwfa_div.sv
// Pipelined restoring divider, four quotient bits per stage, static divisor.
module cwfa_div (
   input  logic                             clock,
   input  logic [cwfa_pkg::DIV_STAGES-1:0]  stage_load,
   input  logic [cwfa_pkg::DIV_NUM_W-1:0]   dividend,
   input  logic [cwfa_pkg::DIV_DEN_W-1:0]   divisor,
   output logic [cwfa_pkg::DIV_NUM_W-1:0]   quotient,
   output logic [cwfa_pkg::DIV_DEN_W-1:0]   remainder
);
   import cwfa_pkg::*;

   // partial remainder and dividend bits, quotient bits shifting in below
   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] num;
   } div_state_type;

   div_state_type st_ff [DIV_STAGES];
   div_state_type st_in [DIV_STAGES];

   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [DIV_DEN_W-1:0] d);
      logic [DIV_DEN_W:0] trial;
      div_state_type      r;
      trial = {s.rem, s.num[DIV_NUM_W-1]};
      r.num = {s.num[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         trial    = trial - {1'b0, d};
         r.num[0] = 1'b1;
      end
      r.rem = trial[DIV_DEN_W-1:0];
      return r;
   endfunction

   // resolve DIV_BITS quotient bits in each stage
   always_comb begin
      div_state_type cur;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            cur.rem = '0;
            cur.num = dividend;
         end else begin
            cur = st_ff[s-1];
         end
         for (int b = 0; b < DIV_BITS; b++) begin
            cur = div_step(cur, divisor);
         end
         st_in[s] = cur;
      end
   end

   // advance each stage when the pipeline moves it
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_load[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign quotient  = st_ff[DIV_STAGES-1].num;
   assign remainder = st_ff[DIV_STAGES-1].rem;

endmodule

### src/cwfa_class.sv
// Region classification of the gather position and its side pipe.
module cwfa_class (
   input  logic                            clock,
   input  logic [cwfa_pkg::DIV_STAGES-1:0] stage_load,
   input  logic [cwfa_pkg::DIV_NUM_W-1:0]  quot_a,
   input  logic [cwfa_pkg::DIV_NUM_W-1:0]  quot_b,
   input  logic [cwfa_pkg::DIV_DEN_W-1:0]  rem_b,
   input  cwfa_pkg::cfg_type               cfg,
   output cwfa_pkg::side_type              side
);
   import cwfa_pkg::*;

   side_type             side_in;
   side_type             side_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0] chn_ext;
   logic [DIV_NUM_W-1:0] chn2_ext;
   logic                 ks_zero;
   logic                 rem_zero;

   // quot_b is the window index k, rem_b the place inside the window
   always_comb begin
      chn_ext  = DIV_NUM_W'(cfg.chn);
      chn2_ext = DIV_NUM_W'({cfg.chn, 1'b0});
      ks_zero  = (cfg.ks == '0);
      rem_zero = (rem_b == '0);
      if (cfg.pool) begin
         side_in.region = (!ks_zero && quot_b == '0) ? REGION_INPUT : REGION_NONE;
      end else if (ks_zero) begin
         // empty window: only the bias at position zero
         side_in.region = rem_zero ? REGION_BIAS : REGION_NONE;
      end else if (quot_b < chn_ext) begin
         side_in.region = REGION_INPUT;
      end else if (quot_b < chn2_ext) begin
         side_in.region = REGION_WEIGHT;
      end else if (quot_b == chn2_ext && rem_zero) begin
         side_in.region = REGION_BIAS;
      end else begin
         side_in.region = REGION_NONE;
      end
      side_in.ch = quot_a[ROW_W-1:0];
      side_in.k  = quot_b[ROW_W-1:0];
      side_in.w  = rem_b[W_W-1:0];
   end

   // carry the classification alongside the second divider pair
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         side_ff[0] <= side_in;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         if (stage_load[s]) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign side = side_ff[DIV_STAGES-1];

endmodule

### src/cwfa_addr.sv
// Address arithmetic: stride scaling, row multiply, final offset and row select.
module cwfa_addr (
   input  logic                             clock,
   input  logic [cwfa_pkg::ADDR_STAGES-1:0] stage_load,
   input  cwfa_pkg::side_type               side,
   input  logic [cwfa_pkg::DIV_NUM_W-1:0]   quot_c,
   input  logic [cwfa_pkg::DIV_DEN_W-1:0]   rem_c,
   input  logic [cwfa_pkg::DIV_NUM_W-1:0]   quot_d,
   input  logic [cwfa_pkg::DIV_DEN_W-1:0]   rem_d,
   input  cwfa_pkg::cfg_type                cfg,
   output cwfa_pkg::result_type             result
);
   import cwfa_pkg::*;

   localparam int SC_W = XY_W + KER_W;
   localparam int RB_W = ROW_W + CHN_W;
   localparam int PR_W = SC_W + MAP_W;

   typedef struct packed {
      region_type       region;
      logic [ROW_W-1:0] ch;
      logic [ROW_W-1:0] k;
      logic [W_W-1:0]   w;
      logic [XY_W-1:0]  x;
      logic [XY_W-1:0]  y;
      logic [SC_W-1:0]  ys;
      logic [SC_W-1:0]  xs;
      logic [ROW_W-1:0] rowbase;
   } scale_type;

   typedef struct packed {
      region_type       region;
      logic [ROW_W-1:0] row;
      logic [OFF_W-1:0] prod;
      logic [SC_W-1:0]  xs;
      logic [W_W-1:0]   w;
      logic [OCH_W-1:0] ch;
      logic [XY_W-1:0]  x;
      logic [XY_W-1:0]  y;
   } mult_type;

   scale_type  a_ff, a_in;
   mult_type   b_ff, b_in;
   result_type c_ff, c_in;

   logic [SC_W-1:0] ymul;
   logic [SC_W-1:0] xmul;
   logic [RB_W-1:0] rb_full;
   logic [PR_W-1:0] prod_full;

   // scale output position by stride, add kernel row and column
   assign ymul    = quot_c[XY_W-1:0] * cfg.st;
   assign xmul    = rem_c[XY_W-1:0] * cfg.st;
   assign rb_full = side.ch * cfg.chn;

   always_comb begin
      a_in.region  = side.region;
      a_in.ch      = side.ch;
      a_in.k       = side.k;
      a_in.w       = side.w;
      a_in.x       = rem_c[XY_W-1:0];
      a_in.y       = quot_c[XY_W-1:0];
      a_in.ys      = ymul + SC_W'(quot_d[KER_W-2:0]);
      a_in.xs      = xmul + SC_W'(rem_d[KER_W-2:0]);
      a_in.rowbase = rb_full[ROW_W-1:0];
   end

   // multiply the window row by the padded row width, pick the table row
   assign prod_full = a_ff.ys * cfg.prw;

   always_comb begin
      b_in.region = a_ff.region;
      b_in.prod   = prod_full[OFF_W-1:0];
      b_in.xs     = a_ff.xs;
      b_in.w      = a_ff.w;
      b_in.ch     = a_ff.ch[OCH_W-1:0];
      b_in.x      = a_ff.x;
      b_in.y      = a_ff.y;
      case (a_ff.region)
         REGION_INPUT:  b_in.row = cfg.pool ? a_ff.ch : a_ff.k;
         REGION_WEIGHT: b_in.row = a_ff.rowbase + a_ff.k - ROW_W'(cfg.chn);
         REGION_BIAS:   b_in.row = a_ff.rowbase;
         default:       b_in.row = '0;
      endcase
   end

   // form the element offset into the output register
   always_comb begin
      c_in.region      = b_ff.region;
      c_in.table_row   = b_ff.row;
      c_in.out_channel = b_ff.ch;
      c_in.out_x       = b_ff.x;
      c_in.out_y       = b_ff.y;
      case (b_ff.region)
         REGION_INPUT:  c_in.element_offset = b_ff.prod + OFF_W'(b_ff.xs);
         REGION_WEIGHT: c_in.element_offset = OFF_W'(b_ff.w);
         REGION_BIAS:   c_in.element_offset = OFF_W'(cfg.ks);
         default:       c_in.element_offset = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         a_ff <= a_in;
      end
      if (stage_load[1]) begin
         b_ff <= b_in;
      end
      if (stage_load[2]) begin
         c_ff <= c_in;
      end
   end

   assign result = c_ff;

endmodule

### src/conv_window_fetch_address_core.sv
// Top level of the convolution / pooling window fetch address generator.
//
//   channel | direction | handshake              | contents
//   req     | in        | req_tvalid/req_tready  | neuron index, element position
//   rsp     | out       | rsp_tvalid/rsp_tready  | region (tuser), row, offset, channel, x, y
//   csr     | in        | csr_we                 | register index and write data
//
// One item enters per cycle unless every stage is full and the output is stalled.
// The pipeline is the input register, two pairs of pipelined dividers (six
// stages, four quotient bits each: neuron split and window split first, then
// row/column split) and three address stages.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled result holds in the output register; empty stages keep filling,
// so the core takes items until every stage holds one.
module conv_window_fetch_address_core (
   input  logic                           clock,
   input  logic                           reset,
   // neuron_index [23:0], element_position [43:24]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cwfa_pkg::REQ_DATA_W-1:0] req_tdata,
   // table_row [19:0], element_offset [43:20], out_channel [59:44],
   // out_x [71:60], out_y [83:72]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cwfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // region [1:0]
   output logic [cwfa_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_we,
   input  logic [cwfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cwfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cwfa_pkg::*;

   cfg_type              cfg;
   side_type             side;
   result_type           result;
   logic [NUM_STAGES-1:0] load;
   logic [NUM_STAGES-1:0] v_ff, v_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [DIV_NUM_W-1:0] quot_a, quot_b, quot_c, quot_d;
   logic [DIV_DEN_W-1:0] rem_a, rem_b, rem_c, rem_d;

   cwfa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a stage loads when it or any stage after it is empty, or the output drains
   always_comb begin
      logic [NUM_STAGES-1:0] below;
      for (int i = 0; i < NUM_STAGES; i++) begin
         below   = {NUM_STAGES{1'b1}} >> (NUM_STAGES - i);
         load[i] = rsp_tready || !(&(v_ff | below));
      end
   end

   assign req_tready = load[STG_IN];

   // advance valid bits with the data
   always_comb begin
      v_in[0] = load[0] ? req_tvalid : v_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         v_in[i] = load[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // capture the input item
   always_ff @(posedge clock) begin
      if (load[STG_IN]) begin
         idx_ff <= req_tdata[IDX_W-1:0];
         pos_ff <= req_tdata[IDX_W +: POS_W];
      end
   end

   // split neuron into channel and plane position, position into window index
   cwfa_div u_div_a (
      .clock      (clock),
      .stage_load (load[STG_DIV1 +: DIV_STAGES]),
      .dividend   (idx_ff),
      .divisor    (cfg.plane),
      .quotient   (quot_a),
      .remainder  (rem_a)
   );

   cwfa_div u_div_b (
      .clock      (clock),
      .stage_load (load[STG_DIV1 +: DIV_STAGES]),
      .dividend   (DIV_NUM_W'(pos_ff)),
      .divisor    (DIV_DEN_W'(cfg.ks)),
      .quotient   (quot_b),
      .remainder  (rem_b)
   );

   // split plane position into row and column, window place into kernel row/col
   cwfa_div u_div_c (
      .clock      (clock),
      .stage_load (load[STG_DIV2 +: DIV_STAGES]),
      .dividend   (rem_a[DIV_NUM_W-1:0]),
      .divisor    (DIV_DEN_W'(cfg.ow)),
      .quotient   (quot_c),
      .remainder  (rem_c)
   );

   cwfa_div u_div_d (
      .clock      (clock),
      .stage_load (load[STG_DIV2 +: DIV_STAGES]),
      .dividend   (rem_b[DIV_NUM_W-1:0]),
      .divisor    (DIV_DEN_W'(cfg.kw)),
      .quotient   (quot_d),
      .remainder  (rem_d)
   );

   cwfa_class u_class (
      .clock      (clock),
      .stage_load (load[STG_DIV2 +: DIV_STAGES]),
      .quot_a     (quot_a),
      .quot_b     (quot_b),
      .rem_b      (rem_b),
      .cfg        (cfg),
      .side       (side)
   );

   cwfa_addr u_addr (
      .clock      (clock),
      .stage_load (load[STG_ADDR +: ADDR_STAGES]),
      .side       (side),
      .quot_c     (quot_c),
      .rem_c      (rem_c),
      .quot_d     (quot_d),
      .rem_d      (rem_d),
      .cfg        (cfg),
      .result     (result)
   );

   // pack the result item
   assign rsp_tvalid = v_ff[NUM_STAGES-1];
   assign rsp_tdata  = RSP_DATA_W'({result.out_y, result.out_x, result.out_channel,
                                    result.element_offset, result.table_row});
   assign rsp_tuser  = result.region;

   // an out-of-range position carries no row and no offset
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.region == REGION_NONE
      |-> result.table_row == '0 && result.element_offset == '0)
      else $error("out-of-range result with nonzero row or offset");

   // an accepted item occupies the input stage on the next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[STG_IN])
      else $error("accepted item missing from input stage");

   // pooling gathers never reach weights or bias
   a_pool_regions: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cfg.pool
      |-> result.region == REGION_INPUT || result.region == REGION_NONE)
      else $error("pooling result in weight or bias region");

   // output column stays inside the configured output width
   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> MAP_W'(result.out_x) < cfg.ow)
      else $error("output column beyond output width");

endmodule
